>>> design/wqsn_pkg.sv
// Shared types and constants for the QoS sequence number block.
package wqsn_pkg;
   localparam int DATA_ENTRIES_DEF   = 64;
   localparam int SHARED_ENTRIES_DEF = 32;
   localparam int ADDR_W  = 48;
   localparam int TID_W   = 4;
   localparam int SEQ_W   = 12;
   localparam int KEY_W   = ADDR_W + TID_W;
   localparam int GROUP_BIT = 40;

   // Request travelling down a chain of cells
   typedef struct packed {
      logic             active;  // lookup still searching
      logic             found;   // a cell already matched
      logic             placed;  // a free cell already claimed
      logic [KEY_W-1:0] key;
      logic [SEQ_W-1:0] seq;     // matched cell's number or shared counter
      logic             bump;    // matched shared entry equaled counter
   } probe_type;
endpackage

>>> design/wqsn_cell.sv
// One table cell: holds a key and last number, passes a probe to its neighbor.
module wqsn_cell
   import wqsn_pkg::*;
#(
   parameter bit SHARED = 1'b0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      clear_mark,   // asserted while idle: mark nothing
   input  probe_type probe_in,
   output probe_type probe_out,
   input  logic      commit,       // write-back pass for the assigned number
   input  logic [SEQ_W-1:0] commit_seq
);
   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [SEQ_W-1:0] last_ff, last_in;
   logic             hit_ff, hit_in;     // this cell owns the current beat
   probe_type        probe_ff, probe_in_c;
   logic             match;

   assign match = valid_ff && key_ff == probe_in.key && probe_in.active && !probe_in.found;

   // Compare, claim or update, then hand the probe on
   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      last_in    = last_ff;
      hit_in     = hit_ff;
      probe_in_c = probe_in;
      if (clear_mark) begin
         hit_in = 1'b0;
      end
      if (match) begin
         probe_in_c.found = 1'b1;
         hit_in = 1'b1;
         if (SHARED) begin
            probe_in_c.bump = (last_ff == probe_in.seq);
         end else begin
            last_in = last_ff + SEQ_W'(1);
            probe_in_c.seq = last_ff + SEQ_W'(1);
         end
      end
      if (commit && hit_ff) begin
         last_in = commit_seq;
      end
      if (commit && !probe_in.found && !probe_in.placed && !valid_ff && probe_in.active) begin
         // claim lowest free slot during the commit pass
         probe_in_c.placed = 1'b1;
         valid_in = 1'b1;
         key_in   = probe_in.key;
         last_in  = commit_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      key_ff   <= key_in;
      last_ff  <= last_in;
      probe_ff <= probe_in_c;
   end
   assign probe_out = probe_ff;
endmodule

>>> design/wqsn_chain.sv
// Row of table cells; probe ripples one cell per cycle.
module wqsn_chain
   import wqsn_pkg::*;
#(
   parameter int ENTRIES = DATA_ENTRIES_DEF,
   parameter bit SHARED  = 1'b0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      clear_mark,
   input  logic      commit,
   input  logic [SEQ_W-1:0] commit_seq,
   input  probe_type probe_head,
   output probe_type probe_tail
);
   probe_type link [ENTRIES+1];
   assign link[0] = probe_head;
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      wqsn_cell #(.SHARED(SHARED)) u_cell (
         .clock, .reset, .clear_mark,
         .probe_in(link[i]), .probe_out(link[i+1]),
         .commit, .commit_seq
      );
   end
   assign probe_tail = link[ENTRIES];
endmodule

>>> design/wifi_qos_sequence_number_assign_top.sv
// Top level: sequencer driving the data and shared cell chains.
//  channel  ports                         handshake
//  request  req_receiver_address .. tid   start & !busy
//  result   rsp_sequence_number, full     rsp_valid strobe, one cycle
// A frame keeps busy high through a search pass and a commit pass, each
// rippling one cell per cycle along the chain it uses, then a done state
// that presents the result. A known data key skips the commit pass. Reset
// clears all valid bits and the shared counter at once. The result cannot
// be held off.
module wifi_qos_sequence_number_assign_top
   import wqsn_pkg::*;
#(
   parameter int DATA_ENTRIES   = DATA_ENTRIES_DEF,
   parameter int SHARED_ENTRIES = SHARED_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ADDR_W-1:0] req_receiver_address,
   input  logic              req_is_qos_data,
   input  logic [TID_W-1:0]  req_traffic_id,
   output logic              rsp_valid,
   output logic [SEQ_W-1:0]  rsp_sequence_number,
   output logic              rsp_table_full
);
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_COMMIT = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   localparam int CNT_W = $clog2(((DATA_ENTRIES > SHARED_ENTRIES) ?
                                  DATA_ENTRIES : SHARED_ENTRIES) + 2);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               use_data_ff, use_data_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SEQ_W-1:0]   ctr_ff, ctr_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic               full_ff, full_in;
   logic               rsp_ff, rsp_in;
   logic [CNT_W-1:0]   len;
   probe_type          head, d_tail, s_tail, tail;
   probe_type          d_head, s_head;
   logic               seq_found_ff;
   logic               commit, clear_mark;

   assign len  = use_data_ff ? CNT_W'(DATA_ENTRIES) : CNT_W'(SHARED_ENTRIES);
   assign tail = use_data_ff ? d_tail : s_tail;

   // Inject probe on the first cycle of each pass
   always_comb begin
      head        = '0;
      head.key    = key_ff;
      head.seq    = ctr_ff;
      head.active = (state_ff == S_SEARCH || state_ff == S_COMMIT) && cnt_ff == '0;
   end
   assign commit     = state_ff == S_COMMIT;
   assign clear_mark = state_ff == S_IDLE;

   // Sequence search, commit and answer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      use_data_in = use_data_ff;
      key_in      = key_ff;
      ctr_in      = ctr_ff;
      seq_in      = seq_ff;
      full_in     = full_ff;
      rsp_in      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               use_data_in = req_is_qos_data && !req_receiver_address[GROUP_BIT];
               key_in = use_data_in ? {req_receiver_address, req_traffic_id}
                                    : {req_receiver_address, {TID_W{1'b0}}};
               cnt_in   = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == len) begin
               full_in = 1'b0;
               if (use_data_ff) begin
                  seq_in = tail.found ? tail.seq : '0;
               end else begin
                  if (tail.found && tail.bump) ctr_in = ctr_ff + SEQ_W'(1);
                  seq_in = (tail.found && tail.bump) ? ctr_ff + SEQ_W'(1) : ctr_ff;
               end
               cnt_in   = '0;
               state_in = tail.found && use_data_ff ? S_DONE : S_COMMIT;
               if (tail.found && use_data_ff) rsp_in = 1'b1;
            end
         end
         S_COMMIT: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == len) begin
               full_in  = !tail.found && !tail.placed;
               rsp_in   = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctr_ff   <= '0;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
         rsp_ff   <= rsp_in;
      end
      cnt_ff      <= cnt_in;
      use_data_ff <= use_data_in;
      key_ff      <= key_in;
      seq_ff      <= seq_in;
      full_ff     <= full_in;
   end

   // Commit pass carries a found flag so known keys are not re-inserted
   always_comb begin
      d_head = head;
      s_head = head;
      d_head.active = head.active && use_data_ff;
      s_head.active = head.active && !use_data_ff;
      d_head.found  = commit && seq_found_ff;
      s_head.found  = commit && seq_found_ff;
   end
   always_ff @(posedge clock) begin
      if (state_ff == S_SEARCH && cnt_ff == len) seq_found_ff <= tail.found;
   end

   wqsn_chain #(.ENTRIES(DATA_ENTRIES), .SHARED(1'b0)) u_data (
      .clock, .reset, .clear_mark, .commit(commit && use_data_ff),
      .commit_seq(seq_ff), .probe_head(d_head), .probe_tail(d_tail)
   );
   wqsn_chain #(.ENTRIES(SHARED_ENTRIES), .SHARED(1'b1)) u_shared (
      .clock, .reset, .clear_mark, .commit(commit && !use_data_ff),
      .commit_seq(seq_ff), .probe_head(s_head), .probe_tail(s_tail)
   );

   assign busy                = state_ff != S_IDLE;
   assign rsp_valid           = rsp_ff;
   assign rsp_sequence_number = seq_ff;
   assign rsp_table_full      = full_ff;
endmodule
